// File: rtl/fpbs_pkg.sv
`timescale 1ns / 1ps
// Package: shared constants, types and command/status structs for the float power block.
package fpbs_pkg;

	localparam int ExponentBits = 31;
	localparam logic [31:0] F32One  = 32'h3F80_0000;
	localparam logic [31:0] F32Qnan = 32'h7FC0_0000;
	localparam logic [31:0] F32Inf  = 32'h7F80_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_ACC,
		ST_WAIT_ACC,
		ST_MUL_SQR,
		ST_WAIT_SQR,
		ST_DONE
	} state_t;

	typedef enum logic [0:0] {
		OP_ACC = 1'b0,
		OP_SQR = 1'b1
	} mul_op_t;

	typedef struct packed {
		logic    load;
		logic    mul_start;
		mul_op_t mul_op;
		logic    shift_exp;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic exp_zero;
		logic exp_lsb;
		logic exp_last;
		logic mul_done;
		logic out_full;
	} dp_sts_t;

endpackage

// File: rtl/fpbs_if.sv
`timescale 1ns / 1ps
// Interfaces: request and result channels with valid/ready handshake.
interface fpbs_in_if (input logic clk);
	logic        valid;
	logic        ready;
	logic [31:0] base_bits;
	logic [30:0] exponent;
	modport source (output valid, base_bits, exponent, input ready);
	modport sink (input valid, base_bits, exponent, output ready);
endinterface

interface fpbs_out_if (input logic clk);
	logic        valid;
	logic        ready;
	logic [31:0] result_bits;
	modport source (output valid, result_bits, input ready);
	modport sink (input valid, result_bits, output ready);
endinterface

// File: rtl/fpbs_fmul.sv
`timescale 1ns / 1ps
// Binary32 multiplier in stages: unpack/normalise, multiply, round/pack.
module fpbs_fmul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] y
);

	// stage 1: specials and normalised significands
	logic        v_s1, v_s2, v_s3;
	logic        sgn_s1, sgn_s2;
	logic        spc_s1, spc_s2;
	logic [31:0] spv_s1, spv_s2;
	logic [23:0] ma_s1, mb_s1;
	logic signed [10:0] xsum_s1, xsum_s2;
	logic [47:0] p_s2;
	logic [31:0] y_s3;

	function automatic logic [4:0] lz23(input logic [22:0] f);
		logic [4:0] n;
		n = 5'd23;
		for (int i = 0; i < 23; i++) begin
			if (f[i]) begin
				n = 5'(22 - i);
			end
		end
		return n;
	endfunction

	logic [7:0] ea, eb;
	logic [22:0] fa, fb;
	logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
	logic [4:0] la, lb;
	logic signed [10:0] xa, xb;
	logic [23:0] na, nb;
	logic spc;
	logic [31:0] spv;

	always_comb begin
		ea = a[30:23]; eb = b[30:23];
		fa = a[22:0];  fb = b[22:0];
		sgn = a[31] ^ b[31];
		a_nan = (ea == 8'hFF) && (fa != '0);
		b_nan = (eb == 8'hFF) && (fb != '0);
		a_inf = (ea == 8'hFF) && (fa == '0);
		b_inf = (eb == 8'hFF) && (fb == '0);
		a_zero = (a[30:0] == '0);
		b_zero = (b[30:0] == '0);
		la = lz23(fa);
		lb = lz23(fb);
		if (ea == '0) begin
			na = {1'b0, fa} << (la + 5'd1);
			xa = 11'sd1 - $signed({6'd0, la}) - 11'sd1 + 11'sd0;
			xa = -$signed({6'd0, la});
		end else begin
			na = {1'b1, fa};
			xa = $signed({3'd0, ea});
		end
		if (eb == '0) begin
			nb = {1'b0, fb} << (lb + 5'd1);
			xb = -$signed({6'd0, lb});
		end else begin
			nb = {1'b1, fb};
			xb = $signed({3'd0, eb});
		end
		spc = 1'b1;
		if (a_nan || b_nan) begin
			spv = fpbs_pkg::F32Qnan;
		end else if (a_inf || b_inf) begin
			spv = (a_zero || b_zero) ? fpbs_pkg::F32Qnan : {sgn, fpbs_pkg::F32Inf[30:0]};
		end else if (a_zero || b_zero) begin
			spv = {sgn, 31'd0};
		end else begin
			spc = 1'b0;
			spv = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else begin
			v_s1 <= start; v_s2 <= v_s1; v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sgn_s1 <= sgn; spc_s1 <= spc; spv_s1 <= spv;
		ma_s1 <= na; mb_s1 <= nb; xsum_s1 <= xa + xb;
		sgn_s2 <= sgn_s1; spc_s2 <= spc_s1; spv_s2 <= spv_s1;
		xsum_s2 <= xsum_s1;
		p_s2 <= ma_s1 * mb_s1;
	end

	// stage 3: normalise, round to nearest even, pack
	logic [47:0] pn;
	logic signed [10:0] e;
	logic [5:0] sh;
	logic [47:0] keep, rem, half;
	logic [48:0] mag;
	logic [31:0] res;

	always_comb begin
		if (p_s2[47]) begin
			pn = p_s2;
			e = xsum_s2 - 11'sd126;
		end else begin
			pn = {p_s2[46:0], 1'b0};
			e = xsum_s2 - 11'sd127;
		end
		if (e >= 11'sd1) begin
			sh = 6'd24;
		end else if ((11'sd25 - e) > 11'sd49) begin
			sh = 6'd49;
		end else begin
			sh = 6'((11'sd25 - e));
		end
		keep = (sh >= 6'd48) ? 48'd0 : (pn >> sh);
		rem = pn & ((sh >= 6'd48) ? {48{1'b1}} : ((48'd1 << sh) - 48'd1));
		half = (sh == 6'd49) ? 48'd0 : (48'd1 << (sh - 6'd1));
		if ((sh == 6'd49) ? 1'b0 : ((rem > half) || ((rem == half) && keep[0]))) begin
			keep = keep + 48'd1;
		end
		if (e >= 11'sd1) begin
			mag = {38'd0, e - 11'sd1} << 23;
			mag = mag + {1'b0, keep};
		end else begin
			mag = {1'b0, keep};
		end
		if (spc_s2) begin
			res = spv_s2;
		end else if (mag >= {17'd0, fpbs_pkg::F32Inf}) begin
			res = {sgn_s2, fpbs_pkg::F32Inf[30:0]};
		end else begin
			res = {sgn_s2, mag[30:0]};
		end
	end

	always_ff @(posedge clk) begin
		y_s3 <= res;
	end

	assign done = v_s3;
	assign y = y_s3;

endmodule

// File: rtl/fpbs_datapath.sv
`timescale 1ns / 1ps
// Datapath: base, accumulator and exponent registers around one shared multiplier.
module fpbs_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  fpbs_pkg::dp_cmd_t cmd,
	input  logic [31:0]       base_bits,
	input  logic [30:0]       exponent,
	input  logic              out_taken,
	output fpbs_pkg::dp_sts_t sts,
	output logic [31:0]       result_bits
);

	logic [31:0] base_q, acc_q, res_q;
	logic [fpbs_pkg::ExponentBits-1:0] exp_q;
	logic        full_q;
	logic        mdone;
	logic [31:0] my, ma;

	assign ma = (cmd.mul_op == fpbs_pkg::OP_SQR) ? base_q : acc_q;

	fpbs_fmul u_fmul (
		.clk(clk), .arst_n(arst_n), .start(cmd.mul_start),
		.a(ma), .b(base_q), .done(mdone), .y(my)
	);

	logic op_q;
	always_ff @(posedge clk) begin
		if (cmd.mul_start) op_q <= cmd.mul_op;
		if (cmd.load) begin
			base_q <= base_bits;
			acc_q  <= fpbs_pkg::F32One;
			exp_q  <= exponent[fpbs_pkg::ExponentBits-1:0];
		end else begin
			if (mdone && op_q == fpbs_pkg::OP_SQR) base_q <= my;
			if (mdone && op_q == fpbs_pkg::OP_ACC) acc_q <= my;
			if (cmd.shift_exp) exp_q <= exp_q >> 1;
		end
		if (cmd.out_load) res_q <= acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (cmd.out_load) begin
			full_q <= 1'b1;
		end else if (out_taken) begin
			full_q <= 1'b0;
		end
	end

	assign sts.exp_zero = (exp_q == '0);
	assign sts.exp_lsb  = exp_q[0];
	assign sts.exp_last = ((exp_q >> 1) == '0);
	assign sts.mul_done = mdone;
	assign sts.out_full = full_q;
	assign result_bits  = res_q;

endmodule

// File: rtl/fpbs_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences multiply-into-accumulator and square rounds.
module fpbs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  fpbs_pkg::dp_sts_t sts,
	output logic              idle,
	output fpbs_pkg::dp_cmd_t cmd
);

	fpbs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= fpbs_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fpbs_pkg::ST_IDLE: if (in_fire) state_d = fpbs_pkg::ST_MUL_ACC;
			fpbs_pkg::ST_MUL_ACC: begin
				if (sts.exp_zero) state_d = fpbs_pkg::ST_DONE;
				else if (sts.exp_lsb) state_d = fpbs_pkg::ST_WAIT_ACC;
				else state_d = fpbs_pkg::ST_MUL_SQR;
			end
			fpbs_pkg::ST_WAIT_ACC: if (sts.mul_done) state_d = fpbs_pkg::ST_MUL_SQR;
			fpbs_pkg::ST_MUL_SQR: begin
				if (sts.exp_last) state_d = fpbs_pkg::ST_MUL_ACC;
				else state_d = fpbs_pkg::ST_WAIT_SQR;
			end
			fpbs_pkg::ST_WAIT_SQR: if (sts.mul_done) state_d = fpbs_pkg::ST_MUL_ACC;
			fpbs_pkg::ST_DONE: if (!sts.out_full) state_d = fpbs_pkg::ST_IDLE;
			default: state_d = fpbs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mul_op = fpbs_pkg::OP_ACC;
		idle = 1'b0;
		unique case (state_q)
			fpbs_pkg::ST_IDLE: begin
				idle = 1'b1;
				cmd.load = in_fire;
			end
			fpbs_pkg::ST_MUL_ACC: cmd.mul_start = !sts.exp_zero && sts.exp_lsb;
			fpbs_pkg::ST_MUL_SQR: begin
				cmd.shift_exp = 1'b1;
				cmd.mul_op = fpbs_pkg::OP_SQR;
				cmd.mul_start = !sts.exp_last;
			end
			fpbs_pkg::ST_DONE: cmd.out_load = !sts.out_full;
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_done_path: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> state_q == fpbs_pkg::ST_DONE) else $error("stray output load");
	a_wait_done: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mul_done |-> (state_q == fpbs_pkg::ST_WAIT_ACC || state_q == fpbs_pkg::ST_WAIT_SQR))
		else $error("multiplier result outside a wait state");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == fpbs_pkg::ST_MUL_ACC) else $error("load did not start a run");
`endif

endmodule

// File: rtl/float_power_by_squaring.sv
`timescale 1ns / 1ps
// Top level: binary32 power by square-and-multiply on one shared multiplier.
//
//  channel | dir | payload                    | handshake
//  req     | in  | base_bits[31:0], exponent  | valid/ready
//  res     | out | result_bits[31:0]          | valid/ready
//
// A request with a nonzero exponent runs k squares (bit length less one) and m
// accumulator multiplies (m set exponent bits) between one accept and the next;
// a zero exponent runs no multiply. Every dependent product waits on the
// three-stage multiplier.
// arst_n clears the controller and the output valid flag.
// A new request is taken only when idle; the result sits in an output
// register so the next request is taken while it waits.
module float_power_by_squaring (
	input logic       clk,
	input logic       arst_n,
	fpbs_in_if.sink   req,
	fpbs_out_if.source res
);

	fpbs_pkg::dp_cmd_t cmd;
	fpbs_pkg::dp_sts_t sts;
	logic idle, in_fire;

	assign req.ready = idle;
	assign in_fire   = req.valid && idle;

	fpbs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .sts(sts), .idle(idle), .cmd(cmd)
	);

	fpbs_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .base_bits(req.base_bits),
		.exponent(req.exponent), .out_taken(res.ready), .sts(sts),
		.result_bits(res.result_bits)
	);

	assign res.valid = sts.out_full;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench: directed and random checks of the float power block against an in-bench predictor.
module testbench;

	localparam int WatchdogLimit = 20000;

	logic clk;
	logic arst_n;

	fpbs_in_if  req (clk);
	fpbs_out_if res (clk);

	float_power_by_squaring u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.res    (res.source)
	);

	// expected powers, oldest first
	logic [31:0] power_queue [$];
	int          mismatches;
	int          results_seen;
	int          requests_sent;
	bit          idle_enabled;
	bit          hold_result;
	bit          timed_out;
	int          quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Predictor: binary32 multiply, round to nearest even, canonical NaN
	// ---------------------------------------------------------------
	function automatic void split_operand(input logic [31:0] v, output logic [23:0] mant,
			output int ex);
		logic [23:0] m;
		int          x;
		m = {1'b0, v[22:0]};
		if (v[30:23] == 8'd0) begin
			x = 1;
			while (!m[23]) begin
				m = m << 1;
				x--;
			end
		end else begin
			m[23] = 1'b1;
			x = int'(v[30:23]);
		end
		mant = m;
		ex = x;
	endfunction

	function automatic logic [31:0] fp_multiply(input logic [31:0] a, input logic [31:0] b);
		logic        sgn;
		logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
		logic [23:0] ma, mb;
		int          xa, xb, e, s, sh;
		logic [63:0] p, keep, rem, half, mag;
		sgn    = a[31] ^ b[31];
		a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 0);
		b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 0);
		a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 0);
		b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 0);
		a_zero = a[30:0] == 0;
		b_zero = b[30:0] == 0;
		if (a_nan || b_nan)
			return fpbs_pkg::F32Qnan;
		if (a_inf || b_inf) begin
			if (a_zero || b_zero)
				return fpbs_pkg::F32Qnan;
			return {sgn, fpbs_pkg::F32Inf[30:0]};
		end
		if (a_zero || b_zero)
			return {sgn, 31'd0};
		split_operand(a, ma, xa);
		split_operand(b, mb, xb);
		p = 64'(ma) * 64'(mb);
		if (p[47]) begin
			e = xa + xb - 126;
		end else begin
			p = p << 1;
			e = xa + xb - 127;
		end
		if (e >= 1) begin
			sh = 24;
		end else begin
			s = 25 - e;
			sh = (s > 49) ? 49 : s;
			e = 0;
		end
		keep = p >> sh;
		rem  = p & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && keep[0]))
			keep++;
		if (e >= 1)
			mag = (64'(e - 1) << 23) + keep;
		else
			mag = keep; // carry out of a subnormal lands on the smallest normal
		if (mag >= 64'(fpbs_pkg::F32Inf))
			return {sgn, fpbs_pkg::F32Inf[30:0]};
		return {sgn, mag[30:0]};
	endfunction

	function automatic logic [31:0] predict_power(input logic [31:0] base,
			input logic [30:0] exponent);
		logic [31:0] acc;
		logic [31:0] sq;
		logic [30:0] n;
		acc = fpbs_pkg::F32One;
		sq  = base;
		n   = exponent;
		while (n != 0) begin
			if (n[0])
				acc = fp_multiply(acc, sq);
			n = n >> 1;
			// no square after the last round
			if (n != 0)
				sq = fp_multiply(sq, sq);
		end
		return acc;
	endfunction

	// ---------------------------------------------------------------
	// Request driver: one request, random idle gaps before it
	// ---------------------------------------------------------------
	task automatic send_request(input logic [31:0] base, input logic [30:0] exponent);
		logic ready_seen;
		while (idle_enabled && ($urandom_range(99) < 14)) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid     <= 1'b1;
		req.base_bits <= base;
		req.exponent  <= exponent;
		power_queue.push_back(predict_power(base, exponent));
		requests_sent++;
		// ready is settled mid-cycle, so its value there decides the coming edge
		ready_seen = 1'b0;
		while (!ready_seen) begin
			@(negedge clk);
			ready_seen = req.ready;
			@(posedge clk);
		end
		// valid is left high; the next call or the caller lowers it
	endtask

	task automatic end_requests();
		req.valid <= 1'b0;
		@(posedge clk);
	endtask

	// random binary32 with a bias towards interesting exponent fields
	function automatic logic [31:0] random_base();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(9))
			0: v[30:23] = 8'd0;                            // subnormal or zero
			1: v[30:23] = 8'hFF;                           // inf or NaN
			2: v[30:23] = 8'(127 + $urandom_range(2) - 1); // near one
			3, 4, 5: v[30:23] = 8'(120 + $urandom_range(14));
			default: ;
		endcase
		if ($urandom_range(15) == 0)
			v[22:0] = 23'd0;
		return v;
	endfunction

	// mostly short exponents keep the run brief; a few take the full width
	function automatic logic [30:0] random_exponent();
		case ($urandom_range(19))
			0: return 31'($urandom);
			1, 2: return 31'($urandom_range(255));
			default: return 31'($urandom_range(40));
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Result side: stall at random, compare with the oldest expectation
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			res.ready <= !hold_result && !(idle_enabled && ($urandom_range(99) < 14));
		end
	end

	// handshake signals are stable mid-cycle and hold what the next edge sees
	always @(negedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			results_seen++;
			if (power_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %h with no request outstanding", res.result_bits);
			end else begin
				logic [31:0] expected_power;
				expected_power = power_queue.pop_front();
				if (res.result_bits !== expected_power) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result_bits mismatch: expected %h, got %h",
							expected_power, res.result_bits);
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either channel
	always @(negedge clk) begin
		if ((req.valid && req.ready) || (res.valid && res.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit && !timed_out) begin
			timed_out = 1'b1;
			$display("watchdog: no progress in %0d cycles", WatchdogLimit);
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	task automatic test_special_cases();
		send_request(32'h7FC0_0001, 31'd0);        // zero exponent on NaN
		send_request(32'h7F80_0000, 31'd0);        // zero exponent on inf
		send_request(32'h8000_0000, 31'd0);        // zero exponent on -0
		send_request(32'h4000_0000, 31'd1);
		send_request(32'hC000_0000, 31'd3);        // negative base, odd power
		send_request(32'hC000_0000, 31'd4);
		send_request(32'h4000_0000, 31'd200);      // overflow to infinity
		send_request(32'h3F00_0000, 31'd200);      // underflow to subnormal / zero
		send_request(32'h3F00_0000, 31'd149);      // smallest subnormal
		send_request(32'h0000_0001, 31'd1);
		send_request(32'h0000_0001, 31'd2);        // subnormal squared to zero
		send_request(32'h807F_FFFF, 31'd3);
		send_request(32'h7F80_0000, 31'd5);
		send_request(32'hFF80_0000, 31'd3);
		send_request(32'h7FFF_FFFF, 31'd7);        // NaN becomes canonical
		send_request(32'hFFC0_0000, 31'd2);
		send_request(32'h3F80_0001, 31'h7FFF_FFFF); // full-width exponent
		send_request(32'hBF80_0000, 31'h7FFF_FFFF);
		send_request(32'h3F7F_FFFF, 31'h4000_0000);
		send_request(32'h7F7F_FFFF, 31'd1);
		send_request(32'h3FB5_04F3, 31'd2);        // rounding near two
		send_request(32'h4049_0FDB, 31'd13);
		end_requests();
	endtask

	task automatic test_random_mix(input int count);
		repeat (count)
			send_request(random_base(), random_exponent());
		end_requests();
	endtask

	// receiver holds off while requests keep coming, so the block stalls its input
	task automatic test_backpressure();
		fork
			begin
				int hold_cycles;
				hold_result = 1'b1;
				hold_cycles = 0;
				while (hold_cycles < 600) begin
					@(posedge clk);
					hold_cycles++;
				end
				hold_result = 1'b0;
			end
			test_random_mix(12);
		join
	endtask

	task automatic drain_results();
		while (power_queue.size() != 0)
			@(posedge clk);
		repeat (300)
			@(posedge clk);
	endtask

	initial begin
		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.base_bits = '0;
		req.exponent  = '0;
		mismatches    = 0;
		results_seen  = 0;
		requests_sent = 0;
		idle_enabled  = 1'b1;
		hold_result   = 1'b0;
		timed_out     = 1'b0;
		quiet_cycles  = 0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_random_mix(500);
		test_backpressure();
		idle_enabled = 1'b0; // stretch with no idling on either side
		test_random_mix(250);
		idle_enabled = 1'b1;
		test_random_mix(330);
		drain_results();

		$display("covered %0d requests and %0d results: special bases, zero and full-width",
			requests_sent, results_seen);
		$display("exponents, overflow, underflow, NaN, random stalls and a long result hold-off");
		if (mismatches == 0 && power_queue.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, power_queue.size());
			$display("FAILURE");
		end
		$finish;
	end

endmodule
